// ===== rtl/sorted_list_table_core_defines.svh =====
// Assertion macros for the sorted list table core.
// Standalone header; included by files that carry concurrent assertions.
`ifndef SORTED_LIST_TABLE_CORE_DEFINES_SVH
`define SORTED_LIST_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define SLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
// Shared types and constants of the sorted list table core.
// No dependencies; used by slt_cell and sorted_list_table_core.
`timescale 1ns / 1ps

package slt_pkg;

    // Fixed field widths of the request and result transactions
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DEL_VAL = 2'd1,
        ACT_DEL_POS = 2'd2,
        ACT_SEARCH  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } t_state;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic    capture;
        logic    commit;
        t_action action;
        logic    found;
        logic    pos_ok;
        logic    room;
    } t_slt_ctl;

    // Per-cell status seen by the neighbor and the sequencer
    typedef struct packed {
        logic valid;
        logic ge;
        logic lb_hit;
        logic eq_hit;
    } t_cell_stat;

endpackage

// ===== rtl/slt_cell.sv =====
// One storage cell of the sorted list table chain.
// Depends on slt_pkg; instantiated once per entry by sorted_list_table_core.
`timescale 1ns / 1ps

module slt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                              i_clk,
    input  slt_pkg::t_slt_ctl                 i_ctl,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    input  logic [CNT_W-1:0]                  i_count,
    input  logic [slt_pkg::POS_W-1:0]         i_position,
    input  logic [slt_pkg::VALUE_W-1:0]       i_left_entry,
    input  logic [slt_pkg::VALUE_W-1:0]       i_right_entry,
    input  slt_pkg::t_cell_stat               i_left_stat,
    output logic [slt_pkg::VALUE_W-1:0]       o_entry,
    output slt_pkg::t_cell_stat               o_stat
);

    logic [slt_pkg::VALUE_W-1:0] r_entry;
    logic                        r_valid;
    logic                        r_ge;
    logic                        r_eq;
    logic                        r_pge;
    logic                        at_end;
    logic                        lb_hit;

    // Compare the incoming key against this entry when a transaction is taken
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_valid <= (CNT_W'(IDX) < i_count);
            r_ge    <= (CNT_W'(IDX) < i_count) && (i_value <= $signed(r_entry));
            r_eq    <= (i_value == $signed(r_entry));
            r_pge   <= ((CNT_W + slt_pkg::POS_W)'(IDX) >=
                        {{CNT_W{1'b0}}, i_position});
        end
    end

    // First free cell, and the lower-bound boundary of the sorted run
    always_comb begin
        at_end = !r_valid && i_left_stat.valid;
        lb_hit = (r_ge || at_end) && !i_left_stat.ge;
    end

    // Shift in from the left on insert, from the right on delete
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            case (i_ctl.action)
                slt_pkg::ACT_INSERT: begin
                    if (i_ctl.room) begin
                        if (lb_hit) begin
                            r_entry <= i_value;
                        end else if (i_left_stat.ge && (r_valid || at_end)) begin
                            r_entry <= i_left_entry;
                        end
                    end
                end
                slt_pkg::ACT_DEL_VAL: begin
                    if (i_ctl.found && r_ge) begin
                        r_entry <= i_right_entry;
                    end
                end
                slt_pkg::ACT_DEL_POS: begin
                    if (i_ctl.pos_ok && r_pge && r_valid) begin
                        r_entry <= i_right_entry;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_entry       = r_entry;
    assign o_stat.valid  = r_valid;
    assign o_stat.ge     = r_ge;
    assign o_stat.lb_hit = lb_hit;
    assign o_stat.eq_hit = r_valid && r_eq;

endmodule

// ===== rtl/sorted_list_table_core.sv =====
// Sorted list table: a chain of CAPACITY compare-and-shift cells with a
// two-state sequencer. In a transaction, the edge that accepts
// start (with busy low) lets every cell compare the key against its entry in
// parallel, and the next edge commits the shift along the chain and registers
// the result. busy is high for that one commit cycle; o_done then pulses for
// exactly one cycle with o_status, o_index and o_count, and start may be
// accepted in that same cycle; no new request is taken while busy is high.
// The receiver cannot stall, so o_done must be sampled when it rises.
// Entries hold no reset value; only positions below the count are ever used.
// Depends on slt_pkg, slt_cell and sorted_list_table_core_defines.svh.
`timescale 1ns / 1ps
`include "sorted_list_table_core_defines.svh"

module sorted_list_table_core #(
    parameter int CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [slt_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [slt_pkg::VALUE_W-1:0]  i_value,
    input  logic [slt_pkg::POS_W-1:0]           i_position,
    output logic                                o_done,
    output logic [slt_pkg::STATUS_W-1:0]        o_status,
    output logic [slt_pkg::INDEX_W-1:0]         o_index,
    output logic [slt_pkg::COUNT_W-1:0]         o_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    slt_pkg::t_state                     r_state;
    slt_pkg::t_state                     n_state;
    slt_pkg::t_action                    r_action;
    logic signed [slt_pkg::VALUE_W-1:0]  r_value;
    logic [slt_pkg::POS_W-1:0]           r_position;
    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    n_count;
    logic                                r_done;
    slt_pkg::t_status                    r_status;
    slt_pkg::t_status                    n_status;
    logic [IDX_W-1:0]                    r_index;
    logic [IDX_W-1:0]                    n_index;

    slt_pkg::t_slt_ctl                   ctl;
    logic                                capture;
    logic                                commit;
    logic                                found;
    logic                                pos_ok;
    logic                                room;
    logic [IDX_W-1:0]                    lb_index;
    logic [CNT_W+slt_pkg::POS_W-1:0]     pos_ext;
    logic [CNT_W+slt_pkg::POS_W-1:0]     cnt_ext;
    logic signed [slt_pkg::VALUE_W-1:0]  cell_value;
    logic [IDX_W+slt_pkg::INDEX_W-1:0]   index_ext;
    logic [CNT_W+slt_pkg::COUNT_W-1:0]   count_ext;

    logic [slt_pkg::VALUE_W-1:0]         w_entry [CAPACITY];
    slt_pkg::t_cell_stat                 w_stat  [CAPACITY];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slt_pkg::ST_IDLE:   if (start) n_state = slt_pkg::ST_COMMIT;
            slt_pkg::ST_COMMIT: n_state = slt_pkg::ST_IDLE;
            default:            n_state = slt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: hold off new transactions while the chain shifts,
    // so every compare sees settled entries and count
    always_comb begin
        busy    = 1'b0;
        commit  = 1'b0;
        case (r_state)
            slt_pkg::ST_IDLE:   commit = 1'b0;
            slt_pkg::ST_COMMIT: begin
                busy   = 1'b1;
                commit = 1'b1;
            end
            default:            commit = 1'b0;
        endcase
        capture = start && !busy;
    end

    // Hold the request fields for the commit cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (capture) begin
            r_action   <= slt_pkg::t_action'(i_action);
            r_value    <= i_value;
            r_position <= i_position;
        end
    end

    // Reduce cell status: any match, and the lower-bound position; check position and room
    always_comb begin
        found    = 1'b0;
        lb_index = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            found = found | w_stat[k].eq_hit;
            if (w_stat[k].lb_hit) begin
                lb_index = lb_index | IDX_W'(k);
            end
        end
        pos_ext = {{CNT_W{1'b0}}, r_position};
        cnt_ext = {{slt_pkg::POS_W{1'b0}}, r_count};
        pos_ok  = (pos_ext < cnt_ext);
        room    = (r_count < CNT_W'(CAPACITY));
    end

    // Broadcast control; cells compare the live key and insert the held one
    always_comb begin
        ctl.capture = capture;
        ctl.commit  = commit;
        ctl.action  = r_action;
        ctl.found   = found;
        ctl.pos_ok  = pos_ok;
        ctl.room    = room;
        cell_value  = commit ? r_value : i_value;
    end

    // Row of cells; cell 0 sees an always-valid, never-greater left neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [slt_pkg::VALUE_W-1:0] left_entry;
        logic [slt_pkg::VALUE_W-1:0] right_entry;
        slt_pkg::t_cell_stat         left_stat;

        if (g == 0) begin : g_head
            assign left_entry = w_entry[g];
            assign left_stat  = '{valid: 1'b1, ge: 1'b0, lb_hit: 1'b0, eq_hit: 1'b0};
        end else begin : g_body
            assign left_entry = w_entry[g-1];
            assign left_stat  = w_stat[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = w_entry[g];
        end else begin : g_mid
            assign right_entry = w_entry[g+1];
        end

        slt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_value       (cell_value),
            .i_count       (r_count),
            .i_position    (i_position),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .i_left_stat   (left_stat),
            .o_entry       (w_entry[g]),
            .o_stat        (w_stat[g])
        );
    end

    // Result and next count of the committing transaction
    always_comb begin
        n_status = slt_pkg::STAT_MISS;
        n_index  = '0;
        n_count  = r_count;
        case (r_action)
            slt_pkg::ACT_INSERT: begin
                if (room) begin
                    n_status = slt_pkg::STAT_OK;
                    n_index  = lb_index;
                    n_count  = r_count + CNT_W'(1);
                end else begin
                    n_status = slt_pkg::STAT_FULL;
                end
            end
            slt_pkg::ACT_DEL_VAL: begin
                if (found) begin
                    n_status = slt_pkg::STAT_OK;
                    n_index  = lb_index;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            slt_pkg::ACT_DEL_POS: begin
                if (pos_ok) begin
                    n_status = slt_pkg::STAT_OK;
                    n_index  = pos_ext[IDX_W-1:0];
                    n_count  = r_count - CNT_W'(1);
                end
            end
            slt_pkg::ACT_SEARCH: begin
                if (found) begin
                    n_status = slt_pkg::STAT_OK;
                    n_index  = lb_index;
                end
            end
            default: begin
            end
        endcase
    end

    // Register the result and advance the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= commit;
            if (commit) begin
                r_count <= n_count;
            end
        end
        if (commit) begin
            r_status <= n_status;
            r_index  <= n_index;
        end
    end

    assign index_ext = {{slt_pkg::INDEX_W{1'b0}}, r_index};
    assign count_ext = {{slt_pkg::COUNT_W{1'b0}}, r_count};
    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_index   = index_ext[slt_pkg::INDEX_W-1:0];
    assign o_count   = count_ext[slt_pkg::COUNT_W-1:0];

    `SLT_ASSERT_NEXT(a_done_after_commit, i_clk, i_rst_n,
        r_state == slt_pkg::ST_COMMIT, o_done, "result strobe missing after commit")
    `SLT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n,
        1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SLT_ASSERT_NOW(a_miss_index_zero, i_clk, i_rst_n,
        o_done && o_status != slt_pkg::STAT_OK, o_index == '0, "nonzero index on failure")
    `SLT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        commit && r_action == slt_pkg::ACT_INSERT && room,
        r_count == $past(r_count) + CNT_W'(1), "insert did not grow the count")
    `SLT_ASSERT_NOW(a_single_boundary, i_clk, i_rst_n,
        commit, $countones(found) <= 1 && (found ? r_count != '0 : 1'b1),
        "match reported in an empty table")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for sorted_list_table_core: a directed table of requests,
// then random fill, drain and mixed phases, checked by a predictor or typed results.
// Depends on slt_pkg and the sorted_list_table_core RTL.
`timescale 1ns / 1ps

module tb;
    import slt_pkg::*;

    localparam int CAP        = 32;
    localparam int RAND_ITEMS = 1630;
    localparam int IDLE_LIMIT = 2000;
    localparam int DIR_N      = 19;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    typedef struct packed {
        t_action                    act;
        logic signed [VALUE_W-1:0]  key;
        logic [POS_W-1:0]           pos;
        logic                       typed;
        t_outcome                   res;
    } t_row;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       start      = 1'b0;
    logic [ACTION_W-1:0]        i_action   = '0;
    logic signed [VALUE_W-1:0]  i_value    = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic                       busy;
    logic                       o_done;
    logic [STATUS_W-1:0]        o_status;
    logic [INDEX_W-1:0]         o_index;
    logic [COUNT_W-1:0]         o_count;

    // Hand-typed expectation that travels with the current request
    logic                       req_typed  = 1'b0;
    t_outcome                   req_expect = '0;

    // Predictor copy of the table
    logic signed [VALUE_W-1:0]  tbl_vals [CAP];
    int                         tbl_count = 0;
    t_outcome                   pending_results [$];

    int fail_count     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int full_refusals  = 0;
    int misses         = 0;
    int peak_count     = 0;
    int idle_cycles    = 0;

    t_row directed_rows [DIR_N];

    sorted_list_table_core #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_action  (i_action),
        .i_value   (i_value),
        .i_position(i_position),
        .o_done    (o_done),
        .o_status  (o_status),
        .o_index   (o_index),
        .o_count   (o_count)
    );

    always #10 i_clk = ~i_clk;

    // Apply one request to the table copy and return the result it must produce
    function automatic t_outcome apply_request(t_action act, logic signed [VALUE_W-1:0] key,
                                               logic [POS_W-1:0] pos);
        t_outcome r;
        int lb;
        int hit;
        int i;
        r.status = STAT_MISS;
        r.index  = '0;
        hit      = -1;
        lb       = 0;
        // first slot whose entry is >= key
        while (lb < tbl_count && key > tbl_vals[lb])
            lb++;
        case (act)
            ACT_INSERT: begin
                if (tbl_count >= CAP) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = tbl_count; i > lb; i--)
                        tbl_vals[i] = tbl_vals[i-1];
                    tbl_vals[lb] = key;
                    tbl_count++;
                    r.status = STAT_OK;
                    r.index  = lb[INDEX_W-1:0];
                end
            end
            ACT_DEL_VAL: begin
                if (lb < tbl_count && tbl_vals[lb] == key)
                    hit = lb;
            end
            ACT_DEL_POS: begin
                if (int'(pos) < tbl_count)
                    hit = int'(pos);
            end
            default: begin
                if (lb < tbl_count && tbl_vals[lb] == key) begin
                    r.status = STAT_OK;
                    r.index  = lb[INDEX_W-1:0];
                end
            end
        endcase
        // close the gap left by a delete
        if (hit >= 0) begin
            for (i = hit; i + 1 < tbl_count; i++)
                tbl_vals[i] = tbl_vals[i+1];
            tbl_count--;
            r.status = STAT_OK;
            r.index  = hit[INDEX_W-1:0];
        end
        r.count = tbl_count[COUNT_W-1:0];
        return r;
    endfunction

    // Check results, then predict the request accepted at this edge
    always @(posedge i_clk) begin : monitor
        t_outcome exp_r;
        t_outcome pred;
        logic     accepted;
        accepted = i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (o_status == STAT_FULL)
                full_refusals++;
            if (o_status == STAT_MISS)
                misses++;
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result with none expected: status %0d index %0d count %0d",
                         $time, o_status, o_index, o_count);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status || o_index !== exp_r.index
                        || o_count !== exp_r.count) begin
                    fail_count++;
                    $display("%0t: mismatch: expected status %0d index %0d count %0d, %s",
                             $time, exp_r.status, exp_r.index, exp_r.count,
                             $sformatf("got status %0d index %0d count %0d",
                                       o_status, o_index, o_count));
                end
            end
        end
        if (accepted) begin
            pred = apply_request(t_action'(i_action), i_value, i_position);
            pending_results.push_back(req_typed ? req_expect : pred);
            items_accepted++;
            if (tbl_count > peak_count)
                peak_count = tbl_count;
        end
        if (accepted || (i_rst_n && o_done))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // Stop a run that has stopped moving
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Hold start low for the gap, present the request, wait for the accepting edge
    task automatic send_request(input t_action act, input logic signed [VALUE_W-1:0] key,
                                input logic [POS_W-1:0] pos, input logic typed,
                                input t_outcome res, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_value    <= key;
        i_position <= pos;
        req_typed  <= typed;
        req_expect <= res;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int       sent;
        int       mode;
        int       phase_len;
        int       burst;
        int       roll;
        int       gap;
        t_action  act;
        logic signed [VALUE_W-1:0] key;
        logic [POS_W-1:0]          pos;

        // after reset, the extremes, duplicates and every miss case
        directed_rows = '{
            '{ACT_SEARCH,  32'sd0,   6'd0,  1'b1, '{STAT_MISS, 5'd0, 6'd0}},
            '{ACT_DEL_VAL, 32'sd5,   6'd0,  1'b1, '{STAT_MISS, 5'd0, 6'd0}},
            '{ACT_DEL_POS, 32'sd0,   6'd0,  1'b1, '{STAT_MISS, 5'd0, 6'd0}},
            '{ACT_INSERT,  32'sd100, 6'd0,  1'b1, '{STAT_OK,   5'd0, 6'd1}},
            '{ACT_INSERT,  VAL_MIN,  6'd0,  1'b1, '{STAT_OK,   5'd0, 6'd2}},
            '{ACT_INSERT,  VAL_MAX,  6'd0,  1'b1, '{STAT_OK,   5'd2, 6'd3}},
            '{ACT_INSERT,  32'sd100, 6'd0,  1'b0, '{STAT_OK,   5'd0, 6'd0}},
            '{ACT_SEARCH,  32'sd100, 6'd0,  1'b0, '{STAT_OK,   5'd0, 6'd0}},
            '{ACT_SEARCH,  VAL_MIN,  6'd0,  1'b1, '{STAT_OK,   5'd0, 6'd4}},
            '{ACT_SEARCH,  VAL_MAX,  6'd0,  1'b1, '{STAT_OK,   5'd3, 6'd4}},
            '{ACT_DEL_POS, 32'sd0,   6'd63, 1'b1, '{STAT_MISS, 5'd0, 6'd4}},
            '{ACT_DEL_POS, 32'sd0,   6'd4,  1'b1, '{STAT_MISS, 5'd0, 6'd4}},
            '{ACT_DEL_POS, 32'sd0,   6'd3,  1'b0, '{STAT_OK,   5'd0, 6'd0}},
            '{ACT_DEL_VAL, 32'sd100, 6'd0,  1'b0, '{STAT_OK,   5'd0, 6'd0}},
            '{ACT_DEL_VAL, 32'sd7,   6'd0,  1'b1, '{STAT_MISS, 5'd0, 6'd2}},
            '{ACT_INSERT,  -32'sd1,  6'd45, 1'b0, '{STAT_OK,   5'd0, 6'd0}},
            '{ACT_DEL_VAL, VAL_MIN,  6'd0,  1'b1, '{STAT_OK,   5'd0, 6'd2}},
            '{ACT_DEL_POS, 32'sd0,   6'd0,  1'b0, '{STAT_OK,   5'd0, 6'd0}},
            '{ACT_SEARCH,  VAL_MAX,  6'd63, 1'b1, '{STAT_MISS, 5'd0, 6'd1}}
        };

        // hold reset, then release it once
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n])
            send_request(directed_rows[n].act, directed_rows[n].key, directed_rows[n].pos,
                         directed_rows[n].typed, directed_rows[n].res, $urandom_range(0, 10));

        // random phases: fill toward full, drain toward empty, or mix
        sent = 0;
        while (sent < RAND_ITEMS) begin
            mode      = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 80);
            burst     = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (mode == 0)
                    act = (roll < 75) ? ACT_INSERT : t_action'($urandom_range(1, 3));
                else if (mode == 1)
                    act = (roll < 35) ? ACT_DEL_VAL : (roll < 70) ? ACT_DEL_POS :
                          (roll < 85) ? ACT_SEARCH : ACT_INSERT;
                else
                    act = t_action'($urandom_range(0, 3));

                // favor stored values and near-duplicates so deletes and searches hit
                roll = $urandom_range(0, 99);
                if (roll < 40 && tbl_count > 0)
                    key = tbl_vals[$urandom_range(0, tbl_count - 1)];
                else if (roll < 70)
                    key = $signed($urandom_range(0, 16)) - 32'sd8;
                else if (roll < 90)
                    key = $urandom;
                else
                    case ($urandom_range(0, 3))
                        0:       key = VAL_MIN;
                        1:       key = VAL_MAX;
                        2:       key = 32'sd0;
                        default: key = -32'sd1;
                    endcase

                if ($urandom_range(0, 99) < 60)
                    pos = POS_W'($urandom_range(0, tbl_count));
                else
                    pos = POS_W'($urandom_range(0, 63));

                gap = burst ? 0 : $urandom_range(0, 10);
                send_request(act, key, pos, 1'b0, '0, gap);
                sent++;
            end
        end
        start <= 1'b0;

        // drain outstanding results, then keep watching for strays
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests and %0d results; %0d full-table refusals, %0d misses.",
                 items_accepted, results_seen, full_refusals, misses);
        $display("Table occupancy peaked at %0d of %0d entries.", peak_count, CAP);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
